// ===== src/wsc_pkg.sv =====
// Shared types and constants of the waveform sample scaler.
package wsc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int CountW   = 25;
  localparam int SampleW  = 16;
  localparam int ProdW    = 48;
  localparam int VoltW    = 48;
  localparam int TimeW    = 64;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  typedef enum logic [CfgIdxW-1:0] {
    RegWordMode    = 3'd0,
    RegLowFirst    = 3'd1,
    RegGain        = 3'd2,
    RegOffset      = 3'd3,
    RegInterval    = 3'd4,
    RegSampleCount = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                     word_mode;
    logic                     low_first;
    logic signed [31:0]       gain;
    logic signed [31:0]       offset;
    logic [31:0]              interval;
    logic [CountW-1:0]        sample_count;
  } cfg_t;

  // One decoded sample on its way from the front to the back.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [TimeW-1:0]          sample_time;
    logic                      last;
  } entry_t;

endpackage

// ===== src/wsc_front.sv =====
// Front end: pairs bytes into samples, stamps time and last flag, pushes to the queue.
module wsc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsc_pkg::cfg_t         cfg,
  input  logic                  rearm,
  input  logic                  in_push,
  input  logic [7:0]            in_data_byte,
  input  logic                  q_full,
  output logic                  q_push,
  output wsc_pkg::entry_t       q_entry
);

  logic                         byte_phase_r;
  logic [7:0]                   held_byte_r;
  logic [wsc_pkg::CountW-1:0]   sample_index_r;
  logic [wsc_pkg::TimeW-1:0]    time_accum_r;

  logic                         active;
  logic                         take;
  logic [wsc_pkg::CountW:0]     index_inc;

  assign active    = sample_index_r < cfg.sample_count;
  assign take      = in_push && !q_full && active;
  assign q_push    = take && byte_phase_r;
  assign index_inc = {1'b0, sample_index_r} + (wsc_pkg::CountW+1)'(1);

  always_comb begin
    if (!cfg.word_mode) begin
      // Byte mode keeps the byte that would have been the low byte of a word.
      if (cfg.low_first) begin
        q_entry.sample = {{8{held_byte_r[7]}}, held_byte_r};
      end else begin
        q_entry.sample = {{8{in_data_byte[7]}}, in_data_byte};
      end
    end else if (cfg.low_first) begin
      q_entry.sample = {in_data_byte, held_byte_r};
    end else begin
      q_entry.sample = {held_byte_r, in_data_byte};
    end
    q_entry.sample_time = time_accum_r;
    q_entry.last        = index_inc == {1'b0, cfg.sample_count};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rearm) begin
      byte_phase_r   <= 1'b0;
      held_byte_r    <= '0;
      sample_index_r <= '0;
      time_accum_r   <= '0;
    end else if (take) begin
      if (!byte_phase_r) begin
        byte_phase_r <= 1'b1;
        held_byte_r  <= in_data_byte;
      end else begin
        byte_phase_r   <= 1'b0;
        sample_index_r <= index_inc[wsc_pkg::CountW-1:0];
        time_accum_r   <= time_accum_r + wsc_pkg::TimeW'(cfg.interval);
      end
    end
  end

endmodule

// ===== src/wsc_fifo.sv =====
// Short queue of decoded samples between the front and the back.
module wsc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsc_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output wsc_pkg::entry_t rd_entry,
  output logic            empty
);

  wsc_pkg::entry_t             mem_r [wsc_pkg::QDepth];
  logic [wsc_pkg::QPtrW-1:0]   wr_ptr_r;
  logic [wsc_pkg::QPtrW-1:0]   rd_ptr_r;
  logic [wsc_pkg::QPtrW:0]     count_r;
  logic                        do_push;
  logic                        do_pop;

  assign full     = count_r == (wsc_pkg::QPtrW+1)'(wsc_pkg::QDepth);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + wsc_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + wsc_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (wsc_pkg::QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (wsc_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

// ===== src/wsc_back.sv =====
// Back end: multiply by gain, subtract offset, saturate, and hold the result item.
module wsc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsc_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  wsc_pkg::entry_t             q_entry,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic signed [wsc_pkg::VoltW-1:0] out_voltage,
  output logic [wsc_pkg::TimeW-1:0]   out_sample_time,
  output logic                        out_last
);

  localparam logic signed [wsc_pkg::VoltW-1:0] VoltMax = {1'b0, {(wsc_pkg::VoltW-1){1'b1}}};
  localparam logic signed [wsc_pkg::VoltW-1:0] VoltMin = {1'b1, {(wsc_pkg::VoltW-1){1'b0}}};

  logic                                s1_v_r;
  logic signed [wsc_pkg::ProdW-1:0]    s1_prod_r;
  logic [wsc_pkg::TimeW-1:0]           s1_time_r;
  logic                                s1_last_r;
  logic                                s2_v_r;
  logic signed [wsc_pkg::VoltW-1:0]    s2_volt_r;
  logic [wsc_pkg::TimeW-1:0]           s2_time_r;
  logic                                s2_last_r;

  logic                                s1_ld;
  logic                                s2_ld;
  logic signed [wsc_pkg::ProdW-1:0]    gain_ext;
  logic signed [wsc_pkg::ProdW-1:0]    sample_ext;
  logic signed [wsc_pkg::ProdW-1:0]    prod;
  logic signed [wsc_pkg::VoltW:0]      prod_ext;
  logic signed [wsc_pkg::VoltW:0]      off_ext;
  logic signed [wsc_pkg::VoltW:0]      diff;
  logic signed [wsc_pkg::VoltW-1:0]    volt_sat;

  // The stall runs back combinationally from the output register to the queue.
  assign s2_ld = !s2_v_r || out_pop;
  assign s1_ld = !s1_v_r || s2_ld;
  assign q_pop = s1_ld && !q_empty;

  assign gain_ext   = wsc_pkg::ProdW'(cfg.gain);
  assign sample_ext = wsc_pkg::ProdW'(q_entry.sample);
  assign prod       = gain_ext * sample_ext;

  // Offset is in 2^-24 V, so it moves up eight bits to line up with the product.
  assign prod_ext = {s1_prod_r[wsc_pkg::ProdW-1], s1_prod_r};
  assign off_ext  = {{(wsc_pkg::VoltW-39){cfg.offset[31]}}, cfg.offset, 8'h00};
  assign diff     = prod_ext - off_ext;

  always_comb begin
    if (diff[wsc_pkg::VoltW] != diff[wsc_pkg::VoltW-1]) begin
      volt_sat = diff[wsc_pkg::VoltW] ? VoltMin : VoltMax;
    end else begin
      volt_sat = diff[wsc_pkg::VoltW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_r <= !q_empty;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_prod_r <= prod;
      s1_time_r <= q_entry.sample_time;
      s1_last_r <= q_entry.last;
    end
    if (s2_ld) begin
      s2_volt_r <= volt_sat;
      s2_time_r <= s1_time_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_empty       = !s2_v_r;
  assign out_voltage     = s2_volt_r;
  assign out_sample_time = s2_time_r;
  assign out_last        = s2_last_r;

endmodule

// ===== src/waveform_sample_scaler.sv =====
// Top level of the waveform sample scaler: configuration registers and the two halves.
//
// Raw waveform bytes go in on the push side, one item a cycle, and every second byte
// of a record completes a sample. A finished sample leaves as one result item with its
// scaled voltage (gain*sample - offset, 2^-32 V), its time stamp (index*interval,
// 2^-48 s) and a last flag on the final sample; bytes past sample_count are taken and
// dropped. The block sustains one byte per cycle while the queue has room; a sample
// whose second byte is taken goes through the queue, the product register and the
// output register to the result side. A four-entry queue sits between the byte
// pairing front and the multiply back, so the input stalls only when that queue fills.
// Writing any valid register index restarts the record at byte zero, sample zero, time
// zero; write configuration only while the block holds no sample.
module waveform_sample_scaler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wsc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [wsc_pkg::CfgDataW-1:0]        cfg_wdata,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [wsc_pkg::VoltW-1:0]    out_voltage,
  output logic [wsc_pkg::TimeW-1:0]           out_sample_time,
  output logic                                out_last
);

  wsc_pkg::cfg_t   cfg_r;
  logic            rearm;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  wsc_pkg::entry_t q_wr_entry;
  wsc_pkg::entry_t q_rd_entry;

  always_comb begin
    case (wsc_pkg::cfg_reg_t'(cfg_index))
      wsc_pkg::RegWordMode,
      wsc_pkg::RegLowFirst,
      wsc_pkg::RegGain,
      wsc_pkg::RegOffset,
      wsc_pkg::RegInterval,
      wsc_pkg::RegSampleCount: rearm = cfg_we;
      default:                 rearm = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_mode    <= 1'b1;
      cfg_r.low_first    <= 1'b1;
      cfg_r.gain         <= '0;
      cfg_r.offset       <= '0;
      cfg_r.interval     <= '0;
      cfg_r.sample_count <= '0;
    end else if (cfg_we) begin
      case (wsc_pkg::cfg_reg_t'(cfg_index))
        wsc_pkg::RegWordMode:    cfg_r.word_mode    <= cfg_wdata[0];
        wsc_pkg::RegLowFirst:    cfg_r.low_first    <= cfg_wdata[0];
        wsc_pkg::RegGain:        cfg_r.gain         <= cfg_wdata;
        wsc_pkg::RegOffset:      cfg_r.offset       <= cfg_wdata;
        wsc_pkg::RegInterval:    cfg_r.interval     <= cfg_wdata;
        wsc_pkg::RegSampleCount: cfg_r.sample_count <= cfg_wdata[wsc_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_full = q_full;

  wsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .rearm        (rearm),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  wsc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  wsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_entry         (q_rd_entry),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_voltage     (out_voltage),
    .out_sample_time (out_sample_time),
    .out_last        (out_last)
  );

endmodule

// ===== src/wsc_checker.sv =====
// Port-level checks of the waveform sample scaler and their binding to the top level.
module wsc_port_checks (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic [wsc_pkg::CfgIdxW-1:0]         cfg_index,
  input logic [wsc_pkg::CfgDataW-1:0]        cfg_wdata,
  input logic                                in_push,
  input logic                                in_full,
  input logic [7:0]                          in_data_byte,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [wsc_pkg::VoltW-1:0]    out_voltage,
  input logic [wsc_pkg::TimeW-1:0]           out_sample_time,
  input logic                                out_last
);

  // Reset leaves no result item behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // Reset leaves the input side free to take an item.
  a_reset_free: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // A waiting result item is not withdrawn.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result item vanished without a pop");

  // A waiting result item keeps its payload.
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=>
      $stable(out_voltage) && $stable(out_sample_time) && $stable(out_last))
    else $error("result item changed while waiting");

endmodule

bind waveform_sample_scaler wsc_port_checks u_port_checks (.*);
